FILE: design/artnet_dmx_packet_receiver_core_macros.svh
// ----------------------------------------------------------------------------
// Art-Net DMX receiver assertion macros
// Shared concurrent assertion forms, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ARTNET_DMX_PACKET_RECEIVER_CORE_MACROS_SVH
`define ARTNET_DMX_PACKET_RECEIVER_CORE_MACROS_SVH

// same-cycle implication
`define ADMX_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ADMX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/artdmx_pkg.sv
// ----------------------------------------------------------------------------
// Art-Net DMX receiver package
// Status and packet-kind codes, header constants and the parser action type.
// ----------------------------------------------------------------------------
package artdmx_pkg;

    typedef enum logic [2:0] {
        ST_DMX_STORED = 3'd0,
        ST_POLL_REPLY = 3'd1,
        ST_IGNORED    = 3'd2,
        ST_RANGE      = 3'd3,
        ST_READ_DATA  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_DMX   = 2'd1,
        KIND_POLL  = 2'd2
    } kind_t;

    localparam logic CMD_PAYLOAD = 1'b0;
    localparam logic CMD_READ    = 1'b1;

    localparam logic [15:0] OPCODE_DMX  = 16'h5000;
    localparam logic [15:0] OPCODE_POLL = 16'h2000;

    localparam logic [7:0] SIGNATURE [8] = '{8'd65, 8'd114, 8'd116, 8'd45,
                                             8'd78, 8'd101, 8'd116, 8'd0};

    localparam int HEADER_LENGTH = 17;

    localparam logic [9:0] POS_OPCODE_LO = 10'd8;
    localparam logic [9:0] POS_OPCODE_HI = 10'd9;
    localparam logic [9:0] POS_UNIV_LO   = 10'd14;
    localparam logic [9:0] POS_UNIV_HI   = 10'd15;
    localparam logic [9:0] POS_DATA      = 10'(HEADER_LENGTH + 1);
    localparam logic [9:0] POS_MAX       = 10'd1023;

    // what one payload byte asks of the channel store and result path
    typedef struct packed {
        logic        wr_en;
        logic [9:0]  wr_channel;
        logic [15:0] universe;
        logic        res_valid;
        status_t     status;
    } pkt_action_t;

endpackage

FILE: design/artdmx_ram.sv
// ----------------------------------------------------------------------------
// Generic dual-port RAM
// One write port and one read port with a registered, read-enabled output.
// ----------------------------------------------------------------------------
module artdmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: design/artdmx_parser.sv
// ----------------------------------------------------------------------------
// Art-Net packet parser
// Tracks byte position, header match, opcode and universe of the packet in
// progress and decides the store write and the end-of-packet status.
// ----------------------------------------------------------------------------
module artdmx_parser import artdmx_pkg::*; #(
    parameter int UNIVERSES = 16,
    parameter int CHANNELS  = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output pkt_action_t action
);

    logic [9:0]  pos_reg, pos_next;
    logic        hdr_ok_reg, hdr_ok_next;
    logic [7:0]  op_lo_reg, op_lo_next;
    kind_t       kind_reg, kind_next;
    logic [15:0] univ_reg, univ_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            hdr_ok_reg <= 1'b1;
            op_lo_reg  <= '0;
            kind_reg   <= KIND_OTHER;
            univ_reg   <= '0;
        end else begin
            pos_reg    <= pos_next;
            hdr_ok_reg <= hdr_ok_next;
            op_lo_reg  <= op_lo_next;
            kind_reg   <= kind_next;
            univ_reg   <= univ_next;
        end
    end

    always_comb begin
        logic [15:0] opcode;
        logic [9:0]  chan;
        opcode      = {data_byte, op_lo_reg};
        chan        = pos_reg - POS_DATA;
        pos_next    = pos_reg;
        hdr_ok_next = hdr_ok_reg;
        op_lo_next  = op_lo_reg;
        kind_next   = kind_reg;
        univ_next   = univ_reg;
        action      = '{wr_en: 1'b0, wr_channel: chan, universe: univ_reg,
                        res_valid: 1'b0, status: ST_IGNORED};
        if (step) begin
            if (pos_reg < 10'd8) begin
                if (data_byte != SIGNATURE[pos_reg[2:0]]) begin
                    hdr_ok_next = 1'b0;
                end
            end else if (pos_reg == POS_OPCODE_LO) begin
                op_lo_next = data_byte;
            end else if (pos_reg == POS_OPCODE_HI) begin
                if (opcode == OPCODE_DMX) begin
                    kind_next = KIND_DMX;
                end else if (opcode == OPCODE_POLL) begin
                    kind_next = KIND_POLL;
                end else begin
                    kind_next = KIND_OTHER;
                end
            end else if (pos_reg == POS_UNIV_LO) begin
                univ_next = {univ_reg[15:8], data_byte};
            end else if (pos_reg == POS_UNIV_HI) begin
                univ_next = {data_byte, univ_reg[7:0]};
            end else if (pos_reg >= POS_DATA) begin
                action.wr_en = hdr_ok_reg && (kind_reg == KIND_DMX)
                               && (32'(univ_reg) < UNIVERSES)
                               && (32'(chan) < CHANNELS);
            end
            if (pos_reg < POS_MAX) begin
                pos_next = pos_reg + 10'd1;
            end
            if (last_byte) begin
                action.res_valid = 1'b1;
                action.universe  = univ_next;
                if (hdr_ok_next && kind_next == KIND_DMX) begin
                    action.status = (32'(univ_next) < UNIVERSES) ? ST_DMX_STORED : ST_RANGE;
                end else if (hdr_ok_next && kind_next == KIND_POLL) begin
                    action.status = ST_POLL_REPLY;
                end
                // start the next packet from a clean slate
                pos_next    = '0;
                hdr_ok_next = 1'b1;
                op_lo_next  = '0;
                kind_next   = KIND_OTHER;
                univ_next   = '0;
            end
        end
    end

endmodule

FILE: design/artnet_dmx_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// Art-Net DMX packet receiver core
// Parses Art-Net payload bytes, stores ArtDmx channel levels per universe and
// reports per packet; read commands return stored levels.
// ----------------------------------------------------------------------------
//   channel | direction | fields
//   s_      | in        | command, data_byte, last_byte, read_universe, read_channel
//   m_      | out       | status, universe, read_value
//
// One item per cycle sustained while m_ready stays high; an item passes an
// input register, the store access stage and the output register. The store
// read port sets the middle stage.
// After reset a clearing pass writes zero to all UNIVERSES*CHANNELS entries
// (8192 by default), one per cycle, with s_ready low throughout.
// A stalled m_ side backs up through the stages to s_ready.
// ----------------------------------------------------------------------------
`include "artnet_dmx_packet_receiver_core_macros.svh"

module artnet_dmx_packet_receiver_core import artdmx_pkg::*; #(
    parameter int UNIVERSES = 16,
    parameter int CHANNELS  = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    input  logic [3:0]  s_read_universe,
    input  logic [8:0]  s_read_channel,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_universe,
    output logic [7:0]  m_read_value
);

    localparam int DEPTH  = UNIVERSES * CHANNELS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WIDE_W = ADDR_W + 10;

    // clearing pass
    logic              clearing_reg, clearing_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    // input stage
    logic       s1_valid_reg, s1_valid_next;
    logic       s1_cmd_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic [3:0] s1_ru_reg;
    logic [8:0] s1_rc_reg;

    // store access stage
    logic        s2_valid_reg, s2_valid_next;
    status_t     s2_status_reg;
    logic [15:0] s2_univ_reg;
    logic        s2_rd_ok_reg;

    // output register
    logic        out_valid_reg, out_valid_next;
    status_t     out_status_reg;
    logic [15:0] out_univ_reg;
    logic [7:0]  out_value_reg;

    logic        out_load, s2_free, s1_proc, s_accept;
    logic        is_read, rd_ok, has_result;
    pkt_action_t action;

    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic [WIDE_W-1:0] wr_addr_wide, rd_addr_wide;

    assign out_load = s2_valid_reg && (!out_valid_reg || m_ready);
    assign s2_free  = !s2_valid_reg || out_load;
    assign s1_proc  = s1_valid_reg && s2_free;
    assign s_ready  = !clearing_reg && (!s1_valid_reg || s1_proc);
    assign s_accept = s_valid && s_ready;

    assign is_read = (s1_cmd_reg == CMD_READ);
    assign rd_ok   = (32'(s1_ru_reg) < UNIVERSES) && (32'(s1_rc_reg) < CHANNELS);

    artdmx_parser #(
        .UNIVERSES (UNIVERSES),
        .CHANNELS  (CHANNELS)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (s1_proc && !is_read),
        .data_byte (s1_byte_reg),
        .last_byte (s1_last_reg),
        .action    (action)
    );

    assign has_result = is_read || action.res_valid;

    assign wr_addr_wide = WIDE_W'(action.universe) * WIDE_W'(CHANNELS)
                          + WIDE_W'(action.wr_channel);
    assign rd_addr_wide = WIDE_W'(s1_ru_reg) * WIDE_W'(CHANNELS) + WIDE_W'(s1_rc_reg);

    always_comb begin
        if (clearing_reg) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end else begin
            ram_we    = action.wr_en;
            ram_waddr = wr_addr_wide[ADDR_W-1:0];
            ram_wdata = s1_byte_reg;
        end
    end

    assign ram_re    = s1_proc && is_read && rd_ok;
    assign ram_raddr = rd_addr_wide[ADDR_W-1:0];

    artdmx_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                clearing_next = 1'b0;
            end
        end
        s1_valid_next = s_accept ? 1'b1 : (s1_proc ? 1'b0 : s1_valid_reg);
        s2_valid_next = s1_proc ? has_result : (out_load ? 1'b0 : s2_valid_reg);
        out_valid_next = out_load ? 1'b1 : ((out_valid_reg && m_ready) ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            clearing_reg  <= clearing_next;
            clr_addr_reg  <= clr_addr_next;
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_cmd_reg  <= s_command;
            s1_byte_reg <= s_data_byte;
            s1_last_reg <= s_last_byte;
            s1_ru_reg   <= s_read_universe;
            s1_rc_reg   <= s_read_channel;
        end
        if (s1_proc) begin
            if (is_read) begin
                s2_status_reg <= ST_READ_DATA;
                s2_univ_reg   <= 16'(s1_ru_reg);
                s2_rd_ok_reg  <= rd_ok;
            end else begin
                s2_status_reg <= action.status;
                s2_univ_reg   <= action.universe;
                s2_rd_ok_reg  <= 1'b0;
            end
        end
        if (out_load) begin
            out_status_reg <= s2_status_reg;
            out_univ_reg   <= s2_univ_reg;
            // store output holds until the next read, so it is still valid here
            out_value_reg  <= s2_rd_ok_reg ? ram_rdata : 8'd0;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_status_reg;
    assign m_universe   = out_univ_reg;
    assign m_read_value = out_value_reg;

    `ADMX_ASSERT_NOW(a_no_accept_clearing, clearing_reg, !s_ready, "item taken during clear")
    `ADMX_ASSERT_NOW(a_no_item_write_clearing, clearing_reg, !action.wr_en,
                     "item write collides with clearing pass")
    `ADMX_ASSERT_NEXT(a_read_reaches_s2, s1_proc && is_read,
                      s2_valid_reg && s2_status_reg == ST_READ_DATA, "read result lost")
    `ADMX_ASSERT_NEXT(a_s2_holds, s2_valid_reg && !out_load,
                      s2_valid_reg && $stable(s2_univ_reg), "pending result dropped")

endmodule
